// ===== src/txtcon_pkg.sv =====
// ----------------------------------------------------------------------------
// txtcon_pkg
// Shared types, codes and helpers of the text console formatter.
// ----------------------------------------------------------------------------
package txtcon_pkg;

  // default geometry
  localparam int unsigned COLUMNS_DEF  = 80;
  localparam int unsigned CELLS_DEF    = 2400;
  localparam int unsigned TAB_STOP_DEF = 4;

  // fixed widths of the item fields
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ADDR_W  = 12;

  // digit sequencing
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned BCD_DIGITS  = 10;
  localparam int unsigned BCD_W       = 4 * BCD_DIGITS;
  localparam int unsigned CONV_BITS   = 4;
  localparam int unsigned CONV_STEPS  = VALUE_W / CONV_BITS;
  localparam int unsigned HEX_DIGITS  = VALUE_W / 4;

  // opcodes
  localparam logic [OP_W-1:0] OP_CHAR = 2'd0;
  localparam logic [OP_W-1:0] OP_DEC  = 2'd1;
  localparam logic [OP_W-1:0] OP_HEX  = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;

  typedef enum logic [1:0] {
    CK_PLAIN,
    CK_NEWLINE,
    CK_RETURN,
    CK_TAB
  } char_kind_e;

  typedef enum logic [2:0] {
    GS_CHAR,
    GS_SPACE,
    GS_MINUS,
    GS_DEC,
    GS_HEX
  } glyph_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REM,
    ST_MOVE,
    ST_CHAR,
    ST_TAB,
    ST_CONV,
    ST_FIND,
    ST_SIGN,
    ST_DEC,
    ST_HEX
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       rem_step;
    logic       move;
    logic       conv_step;
    logic       dec_init;
    logic       emit;
    glyph_sel_e sel;
    logic       last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] in_op;
    char_kind_e      in_kind;
    char_kind_e      ch_kind;
    logic            neg;
    logic            cnt_zero;
    logic            tab_end;
    logic            out_free;
  } status_t;

  function automatic char_kind_e char_kind(input logic [CHAR_W-1:0] ch);
    char_kind_e k;
    case (ch)
      CH_NEWLINE: k = CK_NEWLINE;
      CH_RETURN:  k = CK_RETURN;
      CH_TAB:     k = CK_TAB;
      default:    k = CK_PLAIN;
    endcase
    return k;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] nib);
    logic [CHAR_W-1:0] g;
    if (nib < 4'd10) begin
      g = CH_ZERO + {4'b0, nib};
    end else begin
      g = CH_UPPER_A + {4'b0, nib} - 8'd10;
    end
    return g;
  endfunction

endpackage

// ===== src/txtcon_ctrl.sv =====
// ----------------------------------------------------------------------------
// txtcon_ctrl
// Sequencer: steps the datapath through cursor moves, conversions and writes.
// ----------------------------------------------------------------------------
module txtcon_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  txtcon_pkg::status_t st_i,
  output txtcon_pkg::cmd_t    cmd_o
);
  import txtcon_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (st_i.in_op)
            OP_CHAR: state_d = (st_i.in_kind == CK_PLAIN) ? ST_CHAR : ST_REM;
            OP_DEC:  state_d = ST_CONV;
            OP_HEX:  state_d = ST_HEX;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_REM: begin
        if (st_i.cnt_zero) begin
          state_d = (st_i.ch_kind == CK_TAB) ? ST_TAB : ST_MOVE;
        end
      end
      ST_MOVE: state_d = ST_IDLE;
      ST_CHAR: begin
        if (st_i.out_free) state_d = ST_IDLE;
      end
      ST_TAB: begin
        if (st_i.out_free && st_i.tab_end) state_d = ST_IDLE;
      end
      ST_CONV: begin
        if (st_i.cnt_zero) state_d = ST_FIND;
      end
      ST_FIND: state_d = st_i.neg ? ST_SIGN : ST_DEC;
      ST_SIGN: begin
        if (st_i.out_free) state_d = ST_DEC;
      end
      ST_DEC, ST_HEX: begin
        if (st_i.out_free && st_i.cnt_zero) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = GS_CHAR;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: cmd_o.load      = in_valid_i;
      ST_REM:  cmd_o.rem_step  = 1'b1;
      ST_MOVE: cmd_o.move      = 1'b1;
      ST_CONV: cmd_o.conv_step = 1'b1;
      ST_FIND: cmd_o.dec_init  = 1'b1;
      ST_CHAR: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.sel  = GS_CHAR;
        cmd_o.last = 1'b1;
      end
      ST_TAB: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.sel  = GS_SPACE;
        cmd_o.last = st_i.tab_end;
      end
      ST_SIGN: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.sel  = GS_MINUS;
        cmd_o.last = 1'b0;
      end
      ST_DEC: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.sel  = GS_DEC;
        cmd_o.last = st_i.cnt_zero;
      end
      ST_HEX: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.sel  = GS_HEX;
        cmd_o.last = st_i.cnt_zero;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== src/txtcon_dp.sv =====
// ----------------------------------------------------------------------------
// txtcon_dp
// Datapath: cursor, reciprocal remainder, bcd conversion, output register.
// ----------------------------------------------------------------------------
module txtcon_dp #(
  parameter int unsigned COLUMNS  = txtcon_pkg::COLUMNS_DEF,
  parameter int unsigned CELLS    = txtcon_pkg::CELLS_DEF,
  parameter int unsigned TAB_STOP = txtcon_pkg::TAB_STOP_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [txtcon_pkg::OP_W-1:0]      opcode_i,
  input  logic [txtcon_pkg::CHAR_W-1:0]    character_i,
  input  logic [txtcon_pkg::VALUE_W-1:0]   value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [txtcon_pkg::ADDR_W-1:0]    address_o,
  output logic [txtcon_pkg::CHAR_W-1:0]    glyph_o,
  output logic                             last_o,
  input  txtcon_pkg::cmd_t                 cmd_i,
  output txtcon_pkg::status_t              st_o
);
  import txtcon_pkg::*;

  localparam int unsigned CurW   = $clog2(CELLS);
  localparam int unsigned MaxD   = (COLUMNS > TAB_STOP) ? COLUMNS : TAB_STOP;
  localparam int unsigned RemW   = $clog2(MaxD);
  localparam int unsigned XW     = ((CurW > RemW) ? CurW : RemW) + 1;
  localparam int unsigned ColMod = COLUMNS % CELLS;
  // reciprocal scale, exact for every cursor value and both divisors
  localparam int unsigned RecS     = CurW + RemW;
  localparam int unsigned ColRec   = ((1 << RecS) + COLUMNS - 1) / COLUMNS;
  localparam int unsigned TabRec   = ((1 << RecS) + TAB_STOP - 1) / TAB_STOP;
  localparam int unsigned RemSteps = 2;

  logic [CurW-1:0]    cursor_q, cursor_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [CurW-1:0]    quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [CHAR_W-1:0]  ch_q, ch_d;
  logic               neg_q, neg_d;
  logic               ovalid_q, ovalid_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [CHAR_W-1:0]  glyph_q, glyph_d;
  logic               last_q, last_d;

  char_kind_e         ch_kind;
  logic               out_free;
  logic [CurW-1:0]    cursor_inc;
  logic               cursor_wrap;
  logic [RemW:0]      rem_div, rem_inc;
  logic [RecS-1:0]    rec_mul;
  logic [CurW+RecS-1:0] rec_prod;
  logic [CurW+RemW:0] quo_back;
  logic [CurW-1:0]    rem_full;
  logic [XW-1:0]      row_x, nl_sum;
  logic [BCD_W-1:0]   conv_bcd;
  logic [VALUE_W-1:0] conv_bin;
  logic [CNT_W-1:0]   top_idx;
  logic [CHAR_W-1:0]  sel_glyph;

  assign ch_kind  = char_kind(ch_q);
  assign out_free = !ovalid_q || !out_stall_i;

  // cursor advance with wrap
  assign cursor_wrap = (cursor_q == CurW'(CELLS - 1));
  assign cursor_inc  = cursor_wrap ? '0 : cursor_q + 1'b1;

  // remainder in two steps: quotient by reciprocal, then subtract back
  assign rem_div  = (ch_kind == CK_TAB) ? (RemW+1)'(TAB_STOP) : (RemW+1)'(COLUMNS);
  assign rec_mul  = (ch_kind == CK_TAB) ? RecS'(TabRec) : RecS'(ColRec);
  assign rec_prod = (CurW+RecS)'(cursor_q) * (CurW+RecS)'(rec_mul);
  assign quo_back = (CurW+RemW+1)'(quo_q) * (CurW+RemW+1)'(rem_div);
  assign rem_full = cursor_q - CurW'(quo_back);
  assign rem_inc  = (RemW+1)'(rem_q) + 1'b1;

  // row start and next row start
  assign row_x  = XW'(cursor_q) - XW'(rem_q);
  assign nl_sum = row_x + XW'(ColMod);

  // double dabble, four bits per step
  always_comb begin
    logic [BCD_W-1:0]   b;
    logic [VALUE_W-1:0] v;
    b = bcd_q;
    v = value_q;
    for (int k = 0; k < CONV_BITS; k++) begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
        if (b[i*4 +: 4] >= 4'd5) b[i*4 +: 4] = b[i*4 +: 4] + 4'd3;
      end
      {b, v} = {b, v} << 1;
    end
    conv_bcd = b;
    conv_bin = v;
  end

  // highest nonzero digit
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] != 4'd0) top_idx = CNT_W'(i);
    end
  end

  // glyph select
  always_comb begin
    case (cmd_i.sel)
      GS_CHAR:  sel_glyph = ch_q;
      GS_SPACE: sel_glyph = CH_SPACE;
      GS_MINUS: sel_glyph = CH_MINUS;
      GS_DEC:   sel_glyph = CH_ZERO + {4'b0, bcd_q[cnt_q*4 +: 4]};
      GS_HEX:   sel_glyph = hex_glyph(value_q[VALUE_W-1 -: 4]);
      default:  sel_glyph = ch_q;
    endcase
  end

  // next values
  always_comb begin
    cursor_d = cursor_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    value_d  = value_q;
    bcd_d    = bcd_q;
    ch_d     = ch_q;
    neg_d    = neg_q;
    ovalid_d = ovalid_q && out_stall_i;
    addr_d   = addr_q;
    glyph_d  = glyph_q;
    last_d   = last_q;

    if (cmd_i.load) begin
      ch_d  = character_i;
      neg_d = value_i[VALUE_W-1];
      rem_d = '0;
      bcd_d = '0;
      if (opcode_i == OP_DEC && value_i[VALUE_W-1]) begin
        value_d = ~value_i + 1'b1;
      end else begin
        value_d = value_i;
      end
      case (opcode_i)
        OP_DEC:  cnt_d = CNT_W'(CONV_STEPS - 1);
        OP_HEX:  cnt_d = CNT_W'(HEX_DIGITS - 1);
        default: cnt_d = CNT_W'(RemSteps - 1);
      endcase
    end

    if (cmd_i.rem_step) begin
      if (cnt_q != '0) begin
        quo_d = rec_prod[RecS +: CurW];
      end else begin
        rem_d = RemW'(rem_full);
      end
      cnt_d = cnt_q - 1'b1;
    end

    if (cmd_i.move) begin
      if (ch_kind == CK_NEWLINE) begin
        cursor_d = (nl_sum >= XW'(CELLS)) ? CurW'(nl_sum - XW'(CELLS)) : CurW'(nl_sum);
      end else begin
        cursor_d = CurW'(row_x);
      end
    end

    if (cmd_i.conv_step) begin
      bcd_d   = conv_bcd;
      value_d = conv_bin;
      cnt_d   = cnt_q - 1'b1;
    end

    if (cmd_i.dec_init) begin
      cnt_d = top_idx;
    end

    // one text-memory write
    if (cmd_i.emit) begin
      ovalid_d = 1'b1;
      addr_d   = ADDR_W'(cursor_q);
      glyph_d  = sel_glyph;
      last_d   = cmd_i.last;
      cursor_d = cursor_inc;
      case (cmd_i.sel)
        GS_SPACE: rem_d = RemW'(rem_inc);
        GS_DEC:   cnt_d = cnt_q - 1'b1;
        GS_HEX: begin
          value_d = value_q << 4;
          cnt_d   = cnt_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      cursor_q <= cursor_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    value_q <= value_d;
    bcd_q   <= bcd_d;
    ch_q    <= ch_d;
    neg_q   <= neg_d;
    addr_q  <= addr_d;
    glyph_q <= glyph_d;
    last_q  <= last_d;
  end

  assign out_valid_o = ovalid_q;
  assign address_o   = addr_q;
  assign glyph_o     = glyph_q;
  assign last_o      = last_q;

  // status
  assign st_o.in_op    = opcode_i;
  assign st_o.in_kind  = char_kind(character_i);
  assign st_o.ch_kind  = ch_kind;
  assign st_o.neg      = neg_q;
  assign st_o.cnt_zero = (cnt_q == '0);
  assign st_o.tab_end  = (rem_inc == (RemW+1)'(TAB_STOP)) || cursor_wrap;
  assign st_o.out_free = out_free;

endmodule

// ===== src/text_console_formatter.sv =====
// ----------------------------------------------------------------------------
// text_console_formatter
// Turns put-character, decimal and hex print requests into text-memory writes.
// Input stalls until an item is done. Plain characters and hex go from idle
//   straight to output; tab, newline and return first take the two-step
//   remainder, decimal first runs 8 bcd steps and a leading-digit search.
//   Writes per item: decimal at most 11, tab up to TAB_STOP, newline and
//   return none; one per cycle from the output register unless stalled.
// Reset: cursor to cell 0, no write pending, sequencer idle.
// ----------------------------------------------------------------------------
module text_console_formatter #(
  parameter int unsigned COLUMNS  = txtcon_pkg::COLUMNS_DEF,
  parameter int unsigned CELLS    = txtcon_pkg::CELLS_DEF,
  parameter int unsigned TAB_STOP = txtcon_pkg::TAB_STOP_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [txtcon_pkg::OP_W-1:0]    opcode_i,
  input  logic [txtcon_pkg::CHAR_W-1:0]  character_i,
  input  logic [txtcon_pkg::VALUE_W-1:0] value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [txtcon_pkg::ADDR_W-1:0]  address_o,
  output logic [txtcon_pkg::CHAR_W-1:0]  glyph_o,
  output logic                           last_o
);
  import txtcon_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer
  txtcon_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // datapath
  txtcon_dp #(
    .COLUMNS  (COLUMNS),
    .CELLS    (CELLS),
    .TAB_STOP (TAB_STOP)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .opcode_i    (opcode_i),
    .character_i (character_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .address_o   (address_o),
    .glyph_o     (glyph_o),
    .last_o      (last_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

// ===== test/text_console_formatter_test.sv =====
// ----------------------------------------------------------------------------
// text_console_formatter_test
// Self-checking bench for the console formatter: a directed set of edge
// values, then random bursts of characters, decimal and hex prints with
// random idling on both sides. Every text-memory write is checked against a
// cursor model kept in the bench.
// ----------------------------------------------------------------------------
module text_console_formatter_test;
  import txtcon_pkg::*;

  localparam int unsigned COLUMNS    = COLUMNS_DEF;
  localparam int unsigned CELLS      = CELLS_DEF;
  localparam int unsigned TAB_STOP   = TAB_STOP_DEF;
  localparam int unsigned RAND_ITEMS = 225;
  localparam int unsigned MAX_CYCLES = 400000;
  localparam int unsigned DRAIN      = 64;
  localparam int unsigned MAX_GAP    = 18;
  localparam int unsigned MAX_SHOWN  = 10;

  // opcode the block ignores
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [CHAR_W-1:0] glyph;
    logic              last;
  } cell_write_t;

  // cursor model and queue of text-memory writes still due
  class cell_write_book;
    cell_write_t due_writes[$];
    int unsigned cursor;
    int unsigned mismatches;
    int unsigned writes_seen;
    int unsigned wraps;
    int unsigned n_char, n_dec, n_hex, n_ignored;

    function new();
      cursor = 0;
      mismatches = 0;
      writes_seen = 0;
      wraps = 0;
      n_char = 0;
      n_dec = 0;
      n_hex = 0;
      n_ignored = 0;
    endfunction

    function void move_to(int unsigned next);
      if (next < cursor) begin
        wraps++;
      end
      cursor = next;
    endfunction

    function void write_cell(logic [CHAR_W-1:0] g);
      cell_write_t w;
      w.address = cursor[ADDR_W-1:0];
      w.glyph   = g;
      w.last    = 1'b0;
      due_writes.push_back(w);
      move_to((cursor + 1) % CELLS);
    endfunction

    function void put_byte(logic [CHAR_W-1:0] ch);
      case (ch)
        CH_NEWLINE: move_to((cursor + (COLUMNS - cursor % COLUMNS)) % CELLS);
        CH_RETURN:  cursor = cursor - cursor % COLUMNS;
        CH_TAB: begin
          // at least one space, then up to the next tab stop
          write_cell(CH_SPACE);
          while (cursor % TAB_STOP != 0) begin
            write_cell(CH_SPACE);
          end
        end
        default: write_cell(ch);
      endcase
    endfunction

    function void put_decimal(logic [VALUE_W-1:0] val);
      logic [VALUE_W-1:0] mag;
      logic [CHAR_W-1:0]  digits[10];
      int                 cnt;
      cnt = 0;
      mag = val;
      if (val[VALUE_W-1]) begin
        put_byte(CH_MINUS);
        mag = ~val + 1'b1;
      end
      if (mag == 0) begin
        put_byte(CH_ZERO);
      end else begin
        while (mag != 0) begin
          digits[cnt] = CH_ZERO + CHAR_W'(mag % 10);
          cnt++;
          mag = mag / 10;
        end
        while (cnt > 0) begin
          cnt--;
          put_byte(digits[cnt]);
        end
      end
    endfunction

    function void put_hex(logic [VALUE_W-1:0] val);
      logic [3:0] nib;
      for (int sh = VALUE_W - 4; sh >= 0; sh -= 4) begin
        nib = val[sh +: 4];
        if (nib < 4'd10) begin
          put_byte(CH_ZERO + CHAR_W'(nib));
        end else begin
          put_byte(CH_UPPER_A + CHAR_W'(nib) - 8'd10);
        end
      end
    endfunction

    // work out the writes caused by one accepted input transfer
    function void note_transfer(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                logic [VALUE_W-1:0] val);
      int unsigned before_n;
      before_n = due_writes.size();
      case (op)
        OP_CHAR: begin
          n_char++;
          put_byte(ch);
        end
        OP_DEC: begin
          n_dec++;
          put_decimal(val);
        end
        OP_HEX: begin
          n_hex++;
          put_hex(val);
        end
        default: n_ignored++;
      endcase
      if (due_writes.size() > before_n) begin
        due_writes[due_writes.size() - 1].last = 1'b1;
      end
    endfunction

    function void fail(string what);
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
        $display("mismatch: %s", what);
      end
    endfunction

    // compare one accepted output transfer with the oldest write due
    function void check_write(logic [ADDR_W-1:0] addr, logic [CHAR_W-1:0] g, logic lst);
      cell_write_t w;
      writes_seen++;
      if (due_writes.size() == 0) begin
        fail($sformatf("unexpected write addr=%0d glyph=%02h last=%0b", addr, g, lst));
      end else begin
        w = due_writes.pop_front();
        if (addr !== w.address) begin
          fail($sformatf("address expected %0d got %0d", w.address, addr));
        end
        if (g !== w.glyph) begin
          fail($sformatf("glyph at %0d expected %02h got %02h", w.address, w.glyph, g));
        end
        if (lst !== w.last) begin
          fail($sformatf("last at %0d expected %0b got %0b", w.address, w.last, lst));
        end
      end
    endfunction

    function void check_drained();
      if (due_writes.size() != 0) begin
        fail($sformatf("%0d writes never arrived", due_writes.size()));
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [OP_W-1:0]    opcode;
  logic [CHAR_W-1:0]  character;
  logic [VALUE_W-1:0] value;
  logic               out_valid;
  logic               out_stall;
  logic [ADDR_W-1:0]  address;
  logic [CHAR_W-1:0]  glyph;
  logic               last;

  cell_write_book book = new();
  bit             quiet = 1'b0;
  int unsigned    cycles = 0;

  text_console_formatter #(
    .COLUMNS (COLUMNS),
    .CELLS   (CELLS),
    .TAB_STOP(TAB_STOP)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .opcode_i   (opcode),
    .character_i(character),
    .value_i    (value),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .address_o  (address),
    .glyph_o    (glyph),
    .last_o     (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transfer monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      book.note_transfer(opcode, character, value);
    end
    if (rst_n && out_valid && !out_stall) begin
      book.check_write(address, glyph, last);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stall before each write
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // one input transfer after a random gap
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [VALUE_W-1:0] val);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    character <= ch;
    value     <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off the sender until every write due has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.due_writes.size() != 0) @(posedge clk);
  endtask

  // random item; dense items never move the cursor back to a row start
  task automatic send_random(input bit dense, output bit counted);
    int unsigned        pick;
    logic [OP_W-1:0]    op;
    logic [CHAR_W-1:0]  ch;
    logic [VALUE_W-1:0] val;
    ch  = CHAR_W'($urandom);
    val = $urandom;
    pick = $urandom_range(0, 99);
    if (dense) begin
      op = (pick < 30) ? OP_CHAR : (pick < 65) ? OP_DEC : OP_HEX;
      if (ch == CH_NEWLINE || ch == CH_RETURN) begin
        ch = ch ^ 8'h40;
      end
    end else if (pick < 25) begin
      op = OP_CHAR;
    end else if (pick < 33) begin
      op = OP_CHAR;
      ch = CH_TAB;
    end else if (pick < 43) begin
      op = OP_CHAR;
      ch = CH_NEWLINE;
    end else if (pick < 48) begin
      op = OP_CHAR;
      ch = CH_RETURN;
    end else if (pick < 71) begin
      op = OP_DEC;
    end else if (pick < 95) begin
      op = OP_HEX;
    end else begin
      op = OP_UNUSED;
    end
    // decimal values: mostly short numbers of either sign, some extremes
    if (op == OP_DEC) begin
      case ($urandom_range(0, 5))
        2, 3: val = $urandom_range(0, 999);
        4:    val = $urandom_range(0, 9);
        5: begin
          case ($urandom_range(0, 3))
            0: val = 32'h0000_0000;
            1: val = 32'h8000_0000;
            2: val = 32'h7FFF_FFFF;
            default: val = 32'hFFFF_FFFF;
          endcase
        end
        default: ;
      endcase
      if ($urandom_range(0, 1) == 1 && val < 1000) begin
        val = ~val + 1'b1;
      end
    end
    send_item(op, ch, val);
    counted = (op != OP_UNUSED);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    bit          dense;
    bit          counted;
    bit          paused;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    opcode    = OP_CHAR;
    character = '0;
    value     = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: character extremes, tab from mid-stop and from a stop
    send_item(OP_CHAR, 8'h41, $urandom);
    send_item(OP_CHAR, 8'h00, $urandom);
    send_item(OP_CHAR, 8'hFF, $urandom);
    send_item(OP_CHAR, CH_TAB, $urandom);
    send_item(OP_CHAR, CH_TAB, $urandom);
    send_item(OP_CHAR, 8'h1B, $urandom);
    send_item(OP_CHAR, CH_RETURN, $urandom);
    send_item(OP_CHAR, CH_RETURN, $urandom);
    send_item(OP_CHAR, CH_NEWLINE, $urandom);
    // decimal: zero, both extremes, minus one, ordinary
    send_item(OP_DEC, CHAR_W'($urandom), 32'h0000_0000);
    send_item(OP_DEC, CHAR_W'($urandom), 32'h8000_0000);
    send_item(OP_DEC, CHAR_W'($urandom), 32'h7FFF_FFFF);
    send_item(OP_DEC, CHAR_W'($urandom), 32'hFFFF_FFFF);
    send_item(OP_DEC, CHAR_W'($urandom), 32'd12345);
    send_item(OP_CHAR, CH_NEWLINE, $urandom);
    // hex: all digit values
    send_item(OP_HEX, CHAR_W'($urandom), 32'h0000_0000);
    send_item(OP_HEX, CHAR_W'($urandom), 32'hFFFF_FFFF);
    send_item(OP_HEX, CHAR_W'($urandom), 32'h0123_4567);
    send_item(OP_HEX, CHAR_W'($urandom), 32'h89AB_CDEF);
    // ignored opcode, then two newlines, the second at a row start
    send_item(OP_UNUSED, CHAR_W'($urandom), $urandom);
    send_item(OP_CHAR, CH_NEWLINE, $urandom);
    send_item(OP_CHAR, CH_NEWLINE, $urandom);
    send_item(OP_CHAR, 8'h7F, $urandom);

    // random bursts, some with no idling on either side
    sent = 0;
    paused = 1'b0;
    while (sent < RAND_ITEMS) begin
      burst = $urandom_range(8, 30);
      dense = ($urandom_range(0, 2) == 0);
      quiet = ($urandom_range(0, 3) == 0);
      if (!paused && sent > RAND_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      for (int k = 0; k < burst && sent < RAND_ITEMS; k++) begin
        send_random(dense, counted);
        if (counted) begin
          sent++;
        end
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // drain, then give a trailing write time to show up
    @(posedge clk);
    while (book.due_writes.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    book.check_drained();

    $display("covered %0d character, %0d decimal, %0d hex and %0d ignored items, %0d writes",
             book.n_char, book.n_dec, book.n_hex, book.n_ignored, book.writes_seen);
    $display("cursor wrapped %0d times, %0d mismatches", book.wraps, book.mismatches);
    if (book.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
